>>> hw/rtl/rsl_pkg.sv
// shared types and constants for the release settle latch
`default_nettype none
package rsl_pkg;

  localparam int ROW_BITS = 64;
  localparam int CTL_W    = 8;
  localparam int TIME_W   = 32;
  localparam int CNT_OUT_W = 8;
  localparam logic [31:0] SETTLE_RESET = 32'd100;

  // register byte address decode
  localparam logic REG_SETTLE = 1'b0;

  typedef enum logic [1:0] {
    ACT_SET     = 2'd0,
    ACT_POLL    = 2'd1,
    ACT_FORCE   = 2'd2,
    ACT_RESTART = 2'd3
  } action_t;

  // bitmap update request from the latch logic to the bitmap store
  typedef struct packed {
    logic                we;
    logic                clr;
    logic [1:0]          row;
    logic [ROW_BITS-1:0] data;
  } bm_wr_t;

endpackage
`default_nettype wire

>>> hw/rtl/release_settle_latch_top.sv
// top level of the release settle latch: stream ports, config port, pipeline
//
// channel  dir  handshake          payload
// in_      in   tvalid/tready      tuser: action; tdata: control, pressed, now
// out_     out  tvalid/tready      tdata: ready_res, active_count
// cfg_     in   apb psel/penable   settle_interval at byte address 0
//
// one transaction per cycle while not stalled; result via stage 1 and output register
// the bitmap row is read from memory at acceptance and updated when stage 1 fires,
// a back-to-back update of the same row is forwarded from the last write
// reset gives an empty bitmap, a waiting latch and a settle interval of 100
// a stalled output holds one result in the output register and one in stage 1
`default_nettype none
module release_settle_latch_top
  import rsl_pkg::*;
#(
  parameter int CONTROLS = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,   // [1:0] action
  input  wire logic [47:0] in_tdata,   // [7:0] control, [8] pressed, [40:9] now, rest zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [0] ready_res, [8:1] active_count, rest zero
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int WORDS = (CONTROLS + ROW_BITS - 1) / ROW_BITS;

  // configuration register
  logic [31:0] settle_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_SETTLE) ? settle_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && (cfg_paddr[2] == REG_SETTLE)) begin
      settle_r <= cfg_pwdata;
    end
  end

  // stage 1 holds the accepted transaction while its bitmap row is read
  logic              s1_vld_r;
  action_t           s1_act_r;
  logic [CTL_W-1:0]  s1_ctl_r;
  logic              s1_prs_r;
  logic [TIME_W-1:0] s1_now_r;
  logic              s1_fire;
  logic              in_fire;

  // output register
  logic              out_vld_r;
  logic [15:0]       out_data_r;

  bm_wr_t               bm_wr;
  logic [ROW_BITS-1:0]  row_data;
  logic                 step_ready;
  logic [CNT_OUT_W-1:0] step_count;

  assign s1_fire   = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_act_r <= action_t'(in_tuser);
      s1_ctl_r <= in_tdata[7:0];
      s1_prs_r <= in_tdata[8];
      s1_now_r <= in_tdata[40:9];
    end
  end

  rsl_bitmap #(
    .WORDS (WORDS)
  ) u_bitmap (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_fire),
    .rd_row   (in_tdata[7:6]),
    .sel_row  (s1_ctl_r[7:6]),
    .wr       (bm_wr),
    .row_data (row_data)
  );

  rsl_latch #(
    .CONTROLS (CONTROLS)
  ) u_latch (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_en         (s1_fire),
    .action          (s1_act_r),
    .control         (s1_ctl_r),
    .pressed         (s1_prs_r),
    .now             (s1_now_r),
    .settle_interval (settle_r),
    .row_data        (row_data),
    .wr              (bm_wr),
    .ready_res       (step_ready),
    .active_count    (step_count)
  );

  // result register, freed by the downstream taking the transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_fire) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= {7'd0, step_count, step_ready};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

>>> hw/rtl/rsl_bitmap.sv
// control bitmap store: row memory, row valid flags and write forwarding
`default_nettype none
module rsl_bitmap
  import rsl_pkg::*;
#(
  parameter int WORDS = 2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                rd_en,
  input  wire logic [1:0]          rd_row,
  input  wire logic [1:0]          sel_row,
  input  wire bm_wr_t              wr,
  output logic      [ROW_BITS-1:0] row_data
);

  localparam int ROW_W = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [ROW_BITS-1:0] mem [0:WORDS-1];
  logic [ROW_BITS-1:0] rd_data_r;
  logic [WORDS-1:0]    row_vld_r;
  logic [WORDS-1:0]    row_vld_nxt;
  logic                fwd_vld_r;
  logic [ROW_W-1:0]    fwd_row_r;
  logic [ROW_BITS-1:0] fwd_data_r;
  logic [ROW_W-1:0]    sel_idx;
  logic [ROW_W-1:0]    wr_idx;
  logic [ROW_W-1:0]    rd_idx;

  assign sel_idx = sel_row[ROW_W-1:0];
  assign wr_idx  = wr.row[ROW_W-1:0];
  assign rd_idx  = rd_row[ROW_W-1:0];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr_idx] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  always_comb begin
    row_vld_nxt = row_vld_r;
    if (wr.clr) begin
      row_vld_nxt = '0;
    end else if (wr.we) begin
      row_vld_nxt[wr_idx] = 1'b1;
    end
  end

  // most recent write wins over the registered read of the same row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      fwd_vld_r <= 1'b0;
    end else begin
      row_vld_r <= row_vld_nxt;
      if (wr.clr) begin
        fwd_vld_r <= 1'b0;
      end else if (wr.we) begin
        fwd_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      fwd_row_r  <= wr_idx;
      fwd_data_r <= wr.data;
    end
  end

  always_comb begin
    if (!row_vld_r[sel_idx]) begin
      row_data = '0;
    end else if (fwd_vld_r && (fwd_row_r == sel_idx)) begin
      row_data = fwd_data_r;
    end else begin
      row_data = rd_data_r;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/rsl_latch.sv
// latch state: active count, neutral time and waiting flag, bitmap update
`default_nettype none
module rsl_latch
  import rsl_pkg::*;
#(
  parameter int CONTROLS = 128
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step_en,
  input  wire action_t              action,
  input  wire logic [CTL_W-1:0]     control,
  input  wire logic                 pressed,
  input  wire logic [TIME_W-1:0]    now,
  input  wire logic [31:0]          settle_interval,
  input  wire logic [ROW_BITS-1:0]  row_data,
  output bm_wr_t                    wr,
  output logic                      ready_res,
  output logic [CNT_OUT_W-1:0]      active_count
);

  localparam int CNT_W = $clog2(CONTROLS + 1);
  localparam logic [CTL_W:0] CTL_LIMIT = (CTL_W + 1)'(CONTROLS);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TIME_W-1:0] ntime_r, ntime_nxt;
  logic              known_r, known_nxt;
  logic              waiting_r, waiting_nxt;
  logic              in_range;
  logic              cur_bit;
  logic [TIME_W-1:0] elapsed;
  logic [ROW_BITS-1:0] upd_row;
  logic [8:0]        cnt_wide;

  assign in_range = {1'b0, control} < CTL_LIMIT;
  assign cur_bit  = row_data[control[5:0]];
  assign elapsed  = now - ntime_r;

  always_comb begin
    cnt_nxt     = cnt_r;
    ntime_nxt   = ntime_r;
    known_nxt   = known_r;
    waiting_nxt = waiting_r;
    upd_row     = row_data;
    wr          = '0;
    wr.row      = control[7:6];
    wr.data     = row_data;
    case (action)
      ACT_SET: begin
        if (in_range && (pressed != cur_bit)) begin
          upd_row[control[5:0]] = pressed;
          wr.we   = step_en;
          wr.data = upd_row;
          if (pressed) begin
            cnt_nxt   = cnt_r + 1'b1;
            known_nxt = 1'b0;
          end else begin
            if (cnt_r != '0) begin
              cnt_nxt = cnt_r - 1'b1;
            end
            if (cnt_nxt == '0) begin
              ntime_nxt = now;
              known_nxt = 1'b1;
            end
          end
        end
      end
      ACT_POLL: begin
        if (waiting_r && (cnt_r == '0)) begin
          if (!known_r) begin
            ntime_nxt = now;
            known_nxt = 1'b1;
          end else if (elapsed >= settle_interval) begin
            waiting_nxt = 1'b0;
          end
        end
      end
      ACT_FORCE: begin
        wr.clr      = step_en;
        cnt_nxt     = '0;
        known_nxt   = 1'b1;
        waiting_nxt = 1'b0;
      end
      default: begin
        wr.clr      = step_en;
        cnt_nxt     = '0;
        ntime_nxt   = now;
        known_nxt   = 1'b1;
        waiting_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      ntime_r   <= '0;
      known_r   <= 1'b1;
      waiting_r <= 1'b1;
    end else if (step_en) begin
      cnt_r     <= cnt_nxt;
      ntime_r   <= ntime_nxt;
      known_r   <= known_nxt;
      waiting_r <= waiting_nxt;
    end
  end

  // result reflects the state after this step, count saturated to the field
  assign cnt_wide     = 9'(cnt_nxt);
  assign ready_res    = !waiting_nxt;
  assign active_count = cnt_wide[8] ? 8'hFF : cnt_wide[7:0];

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= CONTROLS)
    else $error("active count above control capacity");

  a_cnt_known: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> !known_r)
    else $error("neutral time marked known while controls active");

  a_force_open: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && (action == ACT_FORCE)) |=> (!waiting_r && (cnt_r == '0)))
    else $error("force ready left latch waiting or controls active");
`endif

endmodule
`default_nettype wire
